// File: hdl/zdsf_pkg.sv
// Package for the ZMODEM data subpacket framer: word types, codes, escape rule.
// No dependencies.
package zdsf_pkg;

	localparam logic [7:0] ZDLE     = 8'h18;
	localparam logic [7:0] XON      = 8'h11;
	localparam logic [7:0] XOFF     = 8'h13;
	localparam logic [7:0] END_BASE = 8'h68;
	localparam logic [1:0] END_WAIT = 2'd3;

	localparam logic [1:0] CFG_IDX_CRC32   = 2'd0;
	localparam logic [1:0] CFG_IDX_ESC_CTL = 2'd1;
	localparam logic [1:0] CFG_IDX_TURBO   = 2'd2;

	localparam int FIFO_DEPTH_DEF = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       closes_packet;
		logic [1:0] end_kind;
	} zdsf_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} zdsf_out_t;

	typedef struct packed {
		logic use_crc32;
		logic escape_all_control;
		logic turbo_mode;
	} zdsf_cfg_t;

	typedef struct packed {
		logic en;
		logic crc32;
	} zdsf_crc_clr_t;

	// queue word: one data byte or one whole trailer
	typedef struct packed {
		logic        is_trailer;
		logic        esc;
		logic        last;
		logic [7:0]  raw;
		logic [7:0]  end_code;
		logic [31:0] trail;
		logic        crc32;
		logic        xon;
	} zdsf_cmd_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_END,
		F_Z1,
		F_Z2,
		F_TRAIL
	} zdsf_fstate_t;

	function automatic logic must_escape(logic [7:0] b, logic [7:0] prev, zdsf_cfg_t cfg);
		logic r;
		r = (b == ZDLE) || (b == XON) || (b == XOFF) || (b == 8'h91) || (b == 8'h93);
		if (!cfg.turbo_mode && ((b == 8'h10) || (b == 8'h90)))
			r = 1'b1;
		if (((b == 8'h0d) || (b == 8'h8d)) && (prev[6:0] == 7'h40))
			r = 1'b1;
		if (cfg.escape_all_control && (b[6:0] < 7'h20))
			r = 1'b1;
		return r;
	endfunction

endpackage

// File: hdl/zmodem_data_subpacket_framer.sv
// ZMODEM data subpacket framer. A payload word is taken while the front is idle and the command
// queue has room; the output port sends one byte per cycle unless out_ready stalls it, so a data
// word costs one output byte, or two when it is escaped. After a closing word the input stays not
// ready while the end code and, for CRC-16, the zero padding pass through the one-byte-per-cycle
// CRC unit and the trailer is queued, longer while the queue is full; the closing word then yields
// 4 to 13 output bytes. Configuration takes effect on the next cycle.
// Depends on zdsf_pkg, zdsf_front, zdsf_fifo, zdsf_back.
module zmodem_data_subpacket_framer import zdsf_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  zdsf_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output zdsf_out_t out_data,
	input  logic      cfg_we,
	input  logic [1:0] cfg_index,
	input  logic      cfg_wdata
);

	zdsf_cfg_t     cfg_q;
	zdsf_crc_clr_t crc_clr;
	logic          fifo_full, fifo_empty, push, pop;
	zdsf_cmd_t     push_cmd, head;

	assign crc_clr.en    = cfg_we && (cfg_index == CFG_IDX_CRC32);
	assign crc_clr.crc32 = cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_CRC32:   cfg_q.use_crc32          <= cfg_wdata;
				CFG_IDX_ESC_CTL: cfg_q.escape_all_control <= cfg_wdata;
				CFG_IDX_TURBO:   cfg_q.turbo_mode         <= cfg_wdata;
				default: ;
			endcase
		end
	end

	zdsf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cfg      (cfg_q),
		.crc_clr  (crc_clr),
		.fifo_full(fifo_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	zdsf_fifo #(
		.W    ($bits(zdsf_cmd_t)),
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (push_cmd),
		.pop   (pop),
		.rdata (head),
		.full  (fifo_full),
		.empty (fifo_empty)
	);

	zdsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fifo_empty(fifo_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: hdl/zdsf_fifo.sv
// Small word queue between framer front and back, register based.
// Generic width and depth; no package dependency.
module zdsf_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign rdata = mem_q[rd_q];
	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: hdl/zdsf_front.sv
// Framer front: accepts input words, runs the CRC, decides data escapes,
// queues data and trailer commands. Depends on zdsf_pkg.
module zdsf_front import zdsf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  zdsf_in_t      in_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  zdsf_cfg_t     cfg,
	input  zdsf_crc_clr_t crc_clr,
	input  logic          fifo_full,
	output logic          push,
	output zdsf_cmd_t     push_cmd
);

	zdsf_fstate_t state_q, state_d;
	logic [31:0]  crc_q, crc_d;
	logic [7:0]   prev_q, prev_d;
	logic [1:0]   kind_q, kind_d;
	logic         data_esc;
	logic [7:0]   end_code;

	function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
		logic [15:0] t;
		t = {crc[15:8], 8'h00};
		for (int i = 0; i < 8; i++)
			t = t[15] ? ({t[14:0], 1'b0} ^ 16'h1021) : {t[14:0], 1'b0};
		return t ^ {crc[7:0], 8'h00} ^ {8'h00, b};
	endfunction

	function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] b);
		logic [31:0] v;
		v = crc ^ {24'h0, b};
		for (int i = 0; i < 8; i++)
			v = v[0] ? ((v >> 1) ^ 32'hedb88320) : (v >> 1);
		return v;
	endfunction

	function automatic logic [31:0] crc_feed(logic [31:0] crc, logic [7:0] b, logic m32);
		return m32 ? crc32_step(crc, b) : {16'h0, crc16_step(crc[15:0], b)};
	endfunction

	assign end_code = END_BASE + {6'b0, kind_q};

	always_comb begin
		state_d  = state_q;
		crc_d    = crc_q;
		prev_d   = prev_q;
		kind_d   = kind_q;
		push     = 1'b0;
		push_cmd = '0;
		in_ready = (state_q == F_IDLE) && !fifo_full;
		data_esc = must_escape(in_data.data_byte, prev_q, cfg);
		case (state_q)
			F_IDLE: begin
				if (in_valid && in_ready) begin
					if (in_data.has_byte) begin
						crc_d           = crc_feed(crc_q, in_data.data_byte, cfg.use_crc32);
						prev_d          = data_esc ? (in_data.data_byte ^ 8'h40)
						                           : in_data.data_byte;
						push            = 1'b1;
						push_cmd.esc    = data_esc;
						push_cmd.last   = !in_data.closes_packet;
						push_cmd.raw    = in_data.data_byte;
					end
					if (in_data.closes_packet) begin
						kind_d  = in_data.end_kind;
						state_d = F_END;
					end
				end
			end
			F_END: begin
				crc_d   = crc_feed(crc_q, end_code, cfg.use_crc32);
				state_d = cfg.use_crc32 ? F_TRAIL : F_Z1;
			end
			F_Z1: begin
				crc_d   = crc_feed(crc_q, 8'h00, 1'b0);
				state_d = F_Z2;
			end
			F_Z2: begin
				crc_d   = crc_feed(crc_q, 8'h00, 1'b0);
				state_d = F_TRAIL;
			end
			F_TRAIL: begin
				if (!fifo_full) begin
					push                = 1'b1;
					push_cmd.is_trailer = 1'b1;
					push_cmd.last       = 1'b1;
					push_cmd.end_code   = end_code;
					push_cmd.trail      = cfg.use_crc32 ? ~crc_q
					                                    : {16'h0, crc_q[7:0], crc_q[15:8]};
					push_cmd.crc32      = cfg.use_crc32;
					push_cmd.xon        = (kind_q == END_WAIT);
					crc_d               = cfg.use_crc32 ? 32'hffffffff : 32'h0;
					prev_d              = 8'h00;
					state_d             = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
		if (crc_clr.en)
			crc_d = crc_clr.crc32 ? 32'hffffffff : 32'h0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			prev_q <= '0;
		end else begin
			crc_q  <= crc_d;
			prev_q <= prev_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
	end

endmodule

// File: hdl/zdsf_back.sv
// Framer back: walks queued commands and sends one output byte per cycle
// unless the queue is empty or out_ready stalls it, inserting ZDLE prefixes. Depends on zdsf_pkg.
module zdsf_back import zdsf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  zdsf_cfg_t cfg,
	input  logic      fifo_empty,
	input  zdsf_cmd_t head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output zdsf_out_t out_data
);

	logic [2:0] idx_q;
	logic       phase_q;
	logic       ov_q;
	zdsf_out_t  od_q;

	logic [2:0] crc_last;
	logic [1:0] sel;
	logic [7:0] tb;
	logic [7:0] raw;
	logic       may_esc;
	logic       piece_fin;
	logic       last_flag;
	logic       hold_zdle;
	logic       emit;
	zdsf_out_t  od_d;

	always_comb begin
		crc_last  = head.crc32 ? 3'd5 : 3'd3;
		sel       = 2'(idx_q - 3'd2);
		case (sel)
			2'd0:    tb = head.trail[7:0];
			2'd1:    tb = head.trail[15:8];
			2'd2:    tb = head.trail[23:16];
			default: tb = head.trail[31:24];
		endcase
		if (!head.is_trailer) begin
			raw       = head.raw;
			may_esc   = head.esc;
			piece_fin = 1'b1;
			last_flag = head.last;
		end else begin
			may_esc = 1'b0;
			if (idx_q == 3'd0)
				raw = ZDLE;
			else if (idx_q == 3'd1)
				raw = head.end_code;
			else if (idx_q <= crc_last) begin
				raw     = tb;
				may_esc = must_escape(tb, 8'h00, cfg);
			end else
				raw = XON;
			piece_fin = ((idx_q == crc_last) && !head.xon) || (idx_q > crc_last);
			last_flag = 1'b1;
		end
		hold_zdle        = may_esc && !phase_q;
		emit             = !fifo_empty && (!ov_q || out_ready);
		pop              = emit && !hold_zdle && piece_fin;
		od_d.out_byte    = hold_zdle ? ZDLE : (raw ^ (may_esc ? 8'h40 : 8'h00));
		od_d.last_of_run = !hold_zdle && piece_fin && last_flag;
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			phase_q <= 1'b0;
			ov_q    <= 1'b0;
		end else if (emit) begin
			ov_q    <= 1'b1;
			phase_q <= hold_zdle;
			if (!hold_zdle)
				idx_q <= piece_fin ? 3'd0 : idx_q + 3'd1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			od_q <= od_d;
	end

endmodule

// File: hdl/zdsf_checker.sv
// Port-level checks for the framer, bound to the top level.
// Depends on zdsf_pkg and zmodem_data_subpacket_framer.
module zdsf_checker import zdsf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input zdsf_in_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input zdsf_out_t out_data,
	input logic      cfg_we,
	input logic [1:0] cfg_index,
	input logic      cfg_wdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	a_zdle_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_of_run |-> out_data.out_byte != ZDLE)
		else $error("run ends on a ZDLE prefix");

	a_zdle_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.out_byte == ZDLE |=> out_valid)
		else $error("no byte ready after ZDLE");

	a_close_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.closes_packet |=> !in_ready)
		else $error("input taken during trailer CRC");

endmodule

bind zmodem_data_subpacket_framer zdsf_checker u_chk (.*);
